>>> rtl/rsdu_pkg.sv
// Shared constants, types and the block order table for the record stream
// decryptor. No dependencies; the locator, cipher and top level use this package.
package rsdu_pkg;

  localparam int DEF_BLOCK_BYTES  = 56;
  localparam int DEF_HEADER_BYTES = 8;
  localparam int KEY_BYTES        = 4;
  localparam int SHUFFLE_WAYS     = 24;

  localparam logic [31:0] LCG_MUL = 32'h41C6_4E6D;
  localparam logic [31:0] LCG_ADD = 32'h0000_6073;

  localparam logic [1:0] ORDER_TABLE [4][24] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3,
      2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3},
    '{2'd1, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
      2'd2, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1, 2'd1, 2'd3, 2'd2,
      2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1},
    '{2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1,
      2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0}
  };

  typedef struct packed {
    logic       is_key;
    logic [1:0] key_lane;
    logic       key_last;
    logic       is_body;
    logic       even_pair;
    logic       rel_odd;
    logic       done;
  } pos_info_t;

  // Destination block that receives source block src under shuffle index sv.
  function automatic logic [1:0] dest_block(input logic [1:0] src, input logic [4:0] sv);
    logic [4:0] col;
    logic [1:0] res;
    logic       found;
    col   = (sv >= 5'(SHUFFLE_WAYS)) ? sv - 5'(SHUFFLE_WAYS) : sv;
    res   = src;
    found = 1'b0;
    for (int d = 0; d < 4; d++) begin
      if (!found && ORDER_TABLE[d][col] == src) begin
        res   = 2'(d);
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/rsdu_in_if.sv
// Input channel of the record stream decryptor: one encrypted byte per word.
// Depends on nothing.
interface rsdu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       record_start;

  modport source(output valid, output cipher_byte, output record_start, input ready);
  modport sink(input valid, input cipher_byte, input record_start, output ready);
endinterface

>>> rtl/rsdu_out_if.sv
// Output channel of the record stream decryptor: one plain byte per word.
// Depends on nothing.
interface rsdu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  plain_byte;
  logic [7:0]  dest_offset;
  logic        record_done;
  logic [15:0] word_sum;

  modport source(output valid, output plain_byte, output dest_offset,
                 output record_done, output word_sum, input ready);
  modport sink(input valid, input plain_byte, input dest_offset,
               input record_done, input word_sum, output ready);
endinterface

>>> rtl/rsdu_locator.sv
// Record position tracking: byte position, source block and offset, and the
// unshuffled destination offset. Depends on rsdu_pkg.
module rsdu_locator #(
  parameter int BLOCK_BYTES  = rsdu_pkg::DEF_BLOCK_BYTES,
  parameter int HEADER_BYTES = rsdu_pkg::DEF_HEADER_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                record_start,
  input  logic [4:0]          shuffle_index,
  output rsdu_pkg::pos_info_t info,
  output logic [7:0]          dest_offset
);

  localparam int RECORD_BYTES = HEADER_BYTES + 4 * BLOCK_BYTES;
  localparam int POS_W        = $clog2(RECORD_BYTES);
  localparam int OFF_W        = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int REL_W        = $clog2(4 * BLOCK_BYTES) + 1;
  localparam logic HDR_ODD    = 1'(HEADER_BYTES % 2);

  logic [POS_W-1:0] pos, pos_next, p_cur;
  logic [1:0]       blk, blk_next, blk_cur;
  logic [OFF_W-1:0] off, off_next, off_cur;
  logic [1:0]       dblk;
  logic [REL_W-1:0] blk_base, rel;
  logic [15:0]      dest_full;

  always_comb begin
    p_cur   = record_start ? '0 : pos;
    blk_cur = record_start ? '0 : blk;
    off_cur = record_start ? '0 : off;

    info.is_key    = (p_cur < POS_W'(rsdu_pkg::KEY_BYTES));
    info.key_lane  = p_cur[1:0];
    info.key_last  = (p_cur == POS_W'(rsdu_pkg::KEY_BYTES - 1));
    info.is_body   = (p_cur >= POS_W'(HEADER_BYTES));
    info.even_pair = (p_cur[0] == HDR_ODD);
    info.done      = (p_cur >= POS_W'(RECORD_BYTES - 1));

    dblk = rsdu_pkg::dest_block(blk_cur, shuffle_index);
    case (dblk)
      2'd0:    blk_base = '0;
      2'd1:    blk_base = REL_W'(BLOCK_BYTES);
      2'd2:    blk_base = REL_W'(2 * BLOCK_BYTES);
      2'd3:    blk_base = REL_W'(3 * BLOCK_BYTES);
      default: blk_base = '0;
    endcase
    rel          = blk_base + REL_W'(off_cur);
    info.rel_odd = rel[0];

    if (info.is_body) begin
      dest_full = 16'(HEADER_BYTES) + 16'(rel);
    end else begin
      dest_full = 16'(p_cur);
    end
    dest_offset = dest_full[7:0];

    pos_next = p_cur + POS_W'(1);
    blk_next = blk_cur;
    off_next = off_cur;
    if (info.is_body) begin
      if (off_cur == OFF_W'(BLOCK_BYTES - 1)) begin
        off_next = '0;
        blk_next = blk_cur + 2'd1;
      end else begin
        off_next = off_cur + OFF_W'(1);
      end
    end
    if (info.done) begin
      pos_next = '0;
      blk_next = '0;
      off_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      blk <= '0;
      off <= '0;
    end else if (fire) begin
      pos <= pos_next;
      blk <= blk_next;
      off <= off_next;
    end
  end

endmodule

>>> rtl/rsdu_cipher.sv
// Key capture, shuffle index and LCG keystream; gives the plain byte.
// Depends on rsdu_pkg and the position information from rsdu_locator.
module rsdu_cipher (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  rsdu_pkg::pos_info_t info,
  input  logic [7:0]          cipher_byte,
  output logic [7:0]          plain_byte,
  output logic [4:0]          shuffle_index
);

  logic [31:0] seed, seed_key, seed_step;
  logic [4:0]  shuffle_raw, shuffle_next;

  always_comb begin
    seed_key = seed;
    case (info.key_lane)
      2'd0:    seed_key[7:0]   = cipher_byte;
      2'd1:    seed_key[15:8]  = cipher_byte;
      2'd2:    seed_key[23:16] = cipher_byte;
      2'd3:    seed_key[31:24] = cipher_byte;
      default: seed_key        = seed;
    endcase
    shuffle_raw  = seed_key[17:13];
    shuffle_next = (shuffle_raw >= 5'(rsdu_pkg::SHUFFLE_WAYS)) ?
                   shuffle_raw - 5'(rsdu_pkg::SHUFFLE_WAYS) : shuffle_raw;

    seed_step = seed * rsdu_pkg::LCG_MUL + rsdu_pkg::LCG_ADD;

    if (!info.is_body) begin
      plain_byte = cipher_byte;
    end else if (info.even_pair) begin
      plain_byte = cipher_byte ^ seed_step[23:16];
    end else begin
      plain_byte = cipher_byte ^ seed[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed          <= '0;
      shuffle_index <= '0;
    end else if (fire) begin
      if (info.is_key) begin
        seed <= seed_key;
      end else if (info.is_body && info.even_pair) begin
        seed <= seed_step;
      end
      if (info.is_key && info.key_last) begin
        shuffle_index <= shuffle_next;
      end
    end
  end

endmodule

>>> rtl/record_stream_decrypt_unshuffle.sv
// Record stream decryptor with block unshuffle: top level with word sum and
// result register. Depends on rsdu_pkg, both channel interfaces, rsdu_locator
// and rsdu_cipher.
// An accepted word is registered and shown on the output in the cycle after.
// Throughput: one byte per cycle; the LCG multiply-add of the cipher step is the
// longest path. Input is accepted while the result register is empty or drained.
// Reset clears the position, seed, shuffle index, word sum and output valid.
module record_stream_decrypt_unshuffle #(
  parameter int BLOCK_BYTES  = rsdu_pkg::DEF_BLOCK_BYTES,
  parameter int HEADER_BYTES = rsdu_pkg::DEF_HEADER_BYTES
) (
  input  logic    clk,
  input  logic    rst,
  rsdu_in_if.sink   din,
  rsdu_out_if.source dout
);

  rsdu_pkg::pos_info_t info;
  logic        fire;
  logic [7:0]  plain, dest;
  logic [4:0]  shuffle_index;
  logic [15:0] sum, sum_base, sum_next, add_val;
  logic        out_valid;
  logic [7:0]  out_plain, out_dest;
  logic        out_done;
  logic [15:0] out_sum;

  assign din.ready = !out_valid || dout.ready;
  assign fire      = din.valid && din.ready;

  rsdu_locator #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_locator (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .record_start (din.record_start),
    .shuffle_index(shuffle_index),
    .info         (info),
    .dest_offset  (dest)
  );

  rsdu_cipher u_cipher (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .info         (info),
    .cipher_byte  (din.cipher_byte),
    .plain_byte   (plain),
    .shuffle_index(shuffle_index)
  );

  always_comb begin
    sum_base = din.record_start ? '0 : sum;
    add_val  = info.rel_odd ? {plain, 8'h00} : {8'h00, plain};
    sum_next = info.is_body ? sum_base + add_val : sum_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      out_valid <= 1'b0;
    end else if (fire) begin
      sum       <= sum_next;
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_plain <= plain;
      out_dest  <= dest;
      out_done  <= info.done;
      out_sum   <= info.done ? sum_next : 16'h0000;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.plain_byte  = out_plain;
  assign dout.dest_offset = out_dest;
  assign dout.record_done = out_done;
  assign dout.word_sum    = out_sum;

endmodule

>>> rtl/rsdu_checker.sv
// Port-level assertions for the record stream decryptor, attached to the top
// level by the bind statement below. Depends on the top level's ports only.
module rsdu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_cipher_byte,
  input logic        in_record_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_plain_byte,
  input logic [7:0]  out_dest_offset,
  input logic        out_record_done,
  input logic [15:0] out_word_sum
);

  // A stalled result word holds until taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_plain_byte) &&
      $stable(out_dest_offset) && $stable(out_record_done) && $stable(out_word_sum))
    else $error("stalled result word changed");

  // A full, stalled result register blocks the input.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted over a stalled result");

  // The word sum is zero except on the last byte of a record.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_record_done |-> out_word_sum == 16'h0000)
    else $error("word sum shown before end of record");

  // The first byte of a record passes through at offset zero in the cycle after.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_record_start |=> out_valid && out_dest_offset == 8'h00 &&
      out_plain_byte == $past(in_cipher_byte) && !out_record_done)
    else $error("record start byte mishandled");

endmodule

bind record_stream_decrypt_unshuffle rsdu_checker u_rsdu_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (din.valid),
  .in_ready       (din.ready),
  .in_cipher_byte (din.cipher_byte),
  .in_record_start(din.record_start),
  .out_valid      (dout.valid),
  .out_ready      (dout.ready),
  .out_plain_byte (dout.plain_byte),
  .out_dest_offset(dout.dest_offset),
  .out_record_done(dout.record_done),
  .out_word_sum   (dout.word_sum)
);
